[design/smf_pkg.sv]
// ----------------------------------------------------------------------------
// smf_pkg: shared types and constants of the sliding median filter
// Window geometry, sample type, sequencer states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int HALF_BITS       = 3;
  localparam int MAX_HALF_WINDOW = 7;
  localparam int WIN_DEPTH       = 2 * MAX_HALF_WINDOW + 1;
  localparam int IDX_BITS        = $clog2(WIN_DEPTH);
  localparam int FILL_BITS       = 4;
  localparam int VIRT_BITS       = FILL_BITS + 1;
  localparam logic [FILL_BITS-1:0] FILL_MAX = '1;
  localparam logic [HALF_BITS-1:0] HALF_RESET = HALF_BITS'(1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [IDX_BITS-1:0]           idx_t;
  typedef logic [HALF_BITS-1:0]          half_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RANK,
    ST_LOAD,
    ST_ADVANCE
  } smf_state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // take a new beat into the window
    logic rank_step;   // compare all lanes against one pivot entry
    logic load_out;    // move the selected median into the output register
    logic flush_push;  // repeat the newest sample once more
    logic end_seq;     // close the sequence
  } smf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit_ok;     // enough samples for a result at this position
    logic rank_done;   // pivot reached the last window entry
    logic out_free;    // output register can take a result now
    logic flush_more;  // more trailing repeats are due
    logic is_last;     // current beat closes the sequence
  } smf_status_t;

endpackage

[design/sliding_median_filter_core.sv]
// ----------------------------------------------------------------------------
// sliding_median_filter_core: running median over an odd sample window
// Emits the median of the 2k+1 samples centred on each position, with the
// first and last samples repeated at the edges; the last beat flushes.
//
//   channel  | dir | handshake               | payload
//   ---------+-----+-------------------------+---------------------------------
//   s_axis   | in  | s_axis_tvalid/tready    | tdata[15:0] sample, tlast is_last
//   m_axis   | out | m_axis_tvalid/tready    | tdata[15:0] median, tlast final
//   cfg      | in  | cfg_we_i                | cfg_wdata_i half_window (k)
//
// A beat that gives no result passes through accept, check and advance.
// Each result adds a rank pass (one pivot entry per cycle over all lanes)
// and a load into the output register. The last beat adds k repeats, each
// through advance and check, plus a rank pass and load per result a repeat gives.
// Only a full output register with tready low stalls, and only the load step.
// Reset clears the window to zero, the fill count and sets k to 1.
// ----------------------------------------------------------------------------
module sliding_median_filter_core
  import smf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [HALF_BITS-1:0]   cfg_wdata_i,    // half_window
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [SAMPLE_BITS-1:0] s_axis_tdata,   // [15:0] sample
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [SAMPLE_BITS-1:0] m_axis_tdata,   // [15:0] median_value
  output logic                   m_axis_tlast
);

  smf_cmd_t    cmd;
  smf_status_t status;
  sample_t     median;

  smf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  smf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_sample_i  (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_median_o (median),
    .out_final_o  (m_axis_tlast)
  );

  assign m_axis_tdata = median;

  // one beat at a time: no new beat right after one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a beat is in progress");

  // a result never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten");

  // trailing repeats only on the last beat of a sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flush_push |-> status.is_last)
    else $error("flush outside the last beat");

  // ranking and input acceptance never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rank_step |-> !s_axis_tready)
    else $error("ranking while idle");

endmodule

[design/smf_ctrl.sv]
// ----------------------------------------------------------------------------
// smf_ctrl: sequencer of the sliding median filter
// Steps each beat through window update, rank passes, result hand-off and
// the trailing flush of the last sample.
// ----------------------------------------------------------------------------
module smf_ctrl
  import smf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  smf_status_t status_i,
  output smf_cmd_t    cmd_o
);

  smf_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = status_i.emit_ok ? ST_RANK : ST_ADVANCE;
      end
      ST_RANK: begin
        cmd_o.rank_step = 1'b1;
        if (status_i.rank_done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        if (status_i.flush_more) begin
          cmd_o.flush_push = 1'b1;
          state_d          = ST_CHECK;
        end else begin
          cmd_o.end_seq = status_i.is_last;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[design/smf_datapath.sv]
// ----------------------------------------------------------------------------
// smf_datapath: window, rank lanes and output register of the median filter
// Holds the sample window as a shift line, ranks every entry against one
// pivot per cycle and picks the entry of middle rank as the median.
// ----------------------------------------------------------------------------
module smf_datapath
  import smf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  half_t       cfg_wdata_i,
  input  sample_t     in_sample_i,
  input  logic        in_last_i,
  input  smf_cmd_t    cmd_i,
  output smf_status_t status_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output sample_t     out_median_o,
  output logic        out_final_o
);

  half_t                 half_q;
  sample_t               win_q [WIN_DEPTH];
  logic                  started_q;
  logic [FILL_BITS-1:0]  fill_q;
  logic [VIRT_BITS-1:0]  virt_q;
  half_t                 step_q;
  logic                  last_q;
  idx_t                  pivot_idx_q;
  logic [IDX_BITS-1:0]   rank_q [WIN_DEPTH];
  logic                  out_valid_q;
  sample_t               out_median_q;
  logic                  out_final_q;

  idx_t                  last_idx;
  sample_t               pivot;
  sample_t               median;
  sample_t               push_val;
  logic                  do_push;

  assign last_idx = {half_q, 1'b0};
  assign pivot    = win_q[pivot_idx_q];
  assign do_push  = cmd_i.accept || cmd_i.flush_push;
  assign push_val = cmd_i.accept ? in_sample_i : win_q[0];

  // filter order register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HALF_RESET;
    end else if (cfg_we_i) begin
      half_q <= cfg_wdata_i;
    end
  end

  // window: fill on the first sample of a sequence, else shift in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_q[i] <= '0;
      end
    end else if (do_push) begin
      if (cmd_i.accept && !started_q) begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
          win_q[i] <= push_val;
        end
      end else begin
        win_q[0] <= push_val;
        for (int i = 1; i < WIN_DEPTH; i++) begin
          win_q[i] <= win_q[i-1];
        end
      end
    end
  end

  // sequence bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      fill_q    <= '0;
      virt_q    <= '0;
      step_q    <= '0;
      last_q    <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        started_q <= 1'b1;
        virt_q    <= VIRT_BITS'(fill_q);
        if (fill_q != FILL_MAX) begin
          fill_q <= fill_q + FILL_BITS'(1);
        end
        step_q <= '0;
        last_q <= in_last_i;
      end
      if (cmd_i.flush_push) begin
        virt_q <= virt_q + VIRT_BITS'(1);
        step_q <= step_q + HALF_BITS'(1);
      end
      if (cmd_i.end_seq) begin
        started_q <= 1'b0;
        fill_q    <= '0;
      end
    end
  end

  // rank lanes: count entries ordered below each lane, ties broken by place
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_idx_q <= '0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        rank_q[i] <= '0;
      end
    end else if (do_push) begin
      pivot_idx_q <= '0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.rank_step) begin
      pivot_idx_q <= pivot_idx_q + IDX_BITS'(1);
      for (int i = 0; i < WIN_DEPTH; i++) begin
        if ((pivot < win_q[i]) || ((pivot == win_q[i]) && (pivot_idx_q < IDX_BITS'(i)))) begin
          rank_q[i] <= rank_q[i] + IDX_BITS'(1);
        end
      end
    end
  end

  // pick the window entry of middle rank
  always_comb begin
    median = '0;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if ((IDX_BITS'(i) <= last_idx) && (rank_q[i] == IDX_BITS'(half_q))) begin
        median = median | win_q[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_median_q <= median;
      out_final_q  <= last_q && (step_q == half_q);
    end
  end

  // status toward the sequencer
  assign status_o.emit_ok    = virt_q >= VIRT_BITS'(half_q);
  assign status_o.rank_done  = pivot_idx_q == last_idx;
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.flush_more = last_q && (step_q != half_q);
  assign status_o.is_last    = last_q;

  assign out_valid_o  = out_valid_q;
  assign out_median_o = out_median_q;
  assign out_final_o  = out_final_q;

endmodule
